>>> hw/rtl/tbg_pkg.sv
`timescale 1ns / 1ps
// Tone burst generator package: widths, register indexes, state record, sine table function.
package tbg_pkg;

	localparam int SAMPLE_RATE_DEF = 44100;
	localparam int SINE_DEPTH_DEF  = 1024;

	localparam int STEP_W = 32;
	localparam int PEAK_W = 15;
	localparam int LEN_W  = 20;
	localparam int SMP_W  = 16;

	localparam int          CFG_IDX_W = 2;
	localparam int          CFG_DAT_W = 32;
	localparam logic [1:0]  REG_PHASE_STEP = 2'd0;
	localparam logic [1:0]  REG_PEAK_AMP   = 2'd1;
	localparam logic [1:0]  REG_BURST_LEN  = 2'd2;

	localparam logic [PEAK_W-1:0] FULL_SCALE = 15'd32767;

	// Per-block sequencer state, kept in the state memory
	typedef struct packed {
		logic              running;
		logic [LEN_W-1:0]  sample_index;
		logic [STEP_W-1:0] phase_acc;
	} tbg_state_t;

	// Quarter-wave sine magnitude for a Q30 fraction of pi/2 (elaboration only)
	function automatic logic [PEAK_W-1:0] sine_q(input logic [31:0] f);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] s;
		logic [63:0] v;
		x  = ({32'd0, f} * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		p  = 64'd1073741824;
		p  = 64'd1073741824 - ((x2 * p) >> 30) / 64'd110;
		p  = 64'd1073741824 - ((x2 * p) >> 30) / 64'd72;
		p  = 64'd1073741824 - ((x2 * p) >> 30) / 64'd42;
		p  = 64'd1073741824 - ((x2 * p) >> 30) / 64'd20;
		p  = 64'd1073741824 - ((x2 * p) >> 30) / 64'd6;
		s  = (x * p) >> 30;
		v  = (s * 64'd32767 + 64'd536870912) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[PEAK_W-1:0];
	endfunction

endpackage

>>> hw/rtl/tbg_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module tbg_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 2,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/tone_burst_generator.sv
`timescale 1ns / 1ps
// Tone burst generator top level: sequencer, state memory, sine ROM, gain divider.
//
//   channel   direction  handshake            beat contents
//   in        sink       in_valid / in_stall  start_req
//   out       source     out_valid/out_stall  sample, last_sample, idle
//   cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A sample tick passes through the LOAD, ROM, MUL1, MUL2, DIV and DONE states to
// the output register; a new input beat is taken only once the sequencer is back
// in idle, so ticks do not overlap. The DIV state runs the 15-step restoring divider.
// An idle tick (no burst running) goes from LOAD straight to DONE.
// Reset clears the config registers and marks the state memory entry invalid
// (reads as zero). in_stall is high while a tick is in work; a finished tick
// waits in the output register while out_stall is high.
module tone_burst_generator import tbg_pkg::*; #(
	parameter int SAMPLE_RATE_HZ   = SAMPLE_RATE_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 start_req,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [SMP_W-1:0]     sample,
	output logic                 last_sample,
	output logic                 idle,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int QB     = IDX_W - 2;
	localparam int QD     = 2 ** QB;
	localparam int FADE_W = $clog2(SAMPLE_RATE_HZ / 200 + 1);
	localparam int DV_W   = FADE_W + PEAK_W;
	localparam int NUM_W  = 2 * PEAK_W + FADE_W;
	localparam int QUO_W  = PEAK_W;
	localparam int CNT_W  = $clog2(QUO_W);
	localparam int ST_W   = $bits(tbg_state_t);

	localparam logic [LEN_W-3:0]  FADE_MAX_L = (LEN_W-2)'(SAMPLE_RATE_HZ / 200);
	localparam logic [FADE_W-1:0] FADE_MAX   = FADE_W'(SAMPLE_RATE_HZ / 200);
	localparam logic [PEAK_W-1:0] SINE_TOP   = sine_q(32'h4000_0000);
	localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(QUO_W - 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOAD = 3'd1;
	localparam logic [2:0] S_ROM  = 3'd2;
	localparam logic [2:0] S_MUL1 = 3'd3;
	localparam logic [2:0] S_MUL2 = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;

	logic [STEP_W-1:0] phase_step_q;
	logic [PEAK_W-1:0] peak_q;
	logic [LEN_W-1:0]  len_q;

	logic start_q;
	logic st_valid_q;
	logic st_re;
	logic st_we;
	logic [ST_W-1:0] st_rdata;
	tbg_state_t st_cur;
	tbg_state_t st_wr;

	logic              run_q;
	logic [LEN_W-1:0]  n_q;
	logic [STEP_W-1:0] acc_q;
	logic [FADE_W-1:0] num_m_q;
	logic [FADE_W-1:0] den_q;
	logic              last_q;
	logic [QB-1:0]     rom_addr_q;
	logic              top_q;
	logic              neg_q;

	logic [PEAK_W-1:0]   mag_q;
	logic [2*PEAK_W-1:0] prod_q;
	logic [NUM_W-1:0]    rem_q;
	logic [NUM_W-1:0]    dsh_q;
	logic [QUO_W-1:0]    quo_q;
	logic [CNT_W-1:0]    cnt_q;

	logic              out_valid_q;
	logic [SMP_W-1:0]  sample_q;
	logic              last_sample_q;
	logic              idle_q;
	logic              out_free;

	// Load-stage decode
	logic              run_d;
	logic [LEN_W-1:0]  n_d;
	logic [STEP_W-1:0] acc_d;
	logic [FADE_W-1:0] fade_d;
	logic [FADE_W-1:0] num_m_d;
	logic [FADE_W-1:0] den_d;
	logic [IDX_W-1:0]  sidx_d;
	logic [QB-1:0]     j_d;
	logic [LEN_W-1:0]  n_inc;

	logic [PEAK_W-1:0] qrom [QD];

	genvar g;
	generate
		for (g = 0; g < QD; g++) begin : g_qrom
			assign qrom[g] = sine_q(32'(g) << (30 - QB));
		end
	endgenerate

	tbg_ram #(
		.WIDTH (ST_W),
		.DEPTH (1)
	) u_state_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr ('0),
		.wdata (st_wr),
		.re    (st_re),
		.raddr ('0),
		.rdata (st_rdata)
	);

	assign cfg_ready   = 1'b1;
	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign sample      = sample_q;
	assign last_sample = last_sample_q;
	assign idle        = idle_q;
	assign out_free    = !(out_valid_q && out_stall);
	assign st_re       = (state_q == S_IDLE) && in_valid;
	assign st_we       = (state_q == S_DONE) && out_free;
	assign n_inc       = n_q + LEN_W'(1);

	always_comb begin
		st_cur = st_valid_q ? tbg_state_t'(st_rdata) : '0;
		run_d  = st_cur.running;
		n_d    = st_cur.sample_index;
		acc_d  = st_cur.phase_acc;
		if (start_q) begin
			run_d = 1'b1;
			n_d   = '0;
			acc_d = '0;
		end
		if (n_d >= len_q) begin
			run_d = 1'b0;
		end
		if (len_q[LEN_W-1:2] > FADE_MAX_L) begin
			fade_d = FADE_MAX;
		end else begin
			fade_d = len_q[FADE_W+1:2];
		end
		if (fade_d != '0 && n_d < LEN_W'(fade_d)) begin
			num_m_d = n_d[FADE_W-1:0];
			den_d   = fade_d;
		end else if (fade_d != '0 && n_d >= len_q - LEN_W'(fade_d)) begin
			num_m_d = FADE_W'(len_q - n_d);
			den_d   = fade_d;
		end else begin
			num_m_d = FADE_W'(1);
			den_d   = FADE_W'(1);
		end
		sidx_d = acc_d[STEP_W-1 -: IDX_W];
		j_d    = sidx_d[QB-1:0];
	end

	always_comb begin
		if (run_q) begin
			st_wr.running      = (n_inc < len_q);
			st_wr.sample_index = n_inc;
			st_wr.phase_acc    = acc_q + phase_step_q;
		end else begin
			st_wr.running      = 1'b0;
			st_wr.sample_index = n_q;
			st_wr.phase_acc    = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			peak_q       <= '0;
			len_q        <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PHASE_STEP: phase_step_q <= cfg_data[STEP_W-1:0];
				REG_PEAK_AMP:   peak_q       <= cfg_data[PEAK_W-1:0];
				REG_BURST_LEN:  len_q        <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= run_d ? S_ROM : S_DONE;
				end
				S_ROM:  state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == CNT_LAST) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_valid_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				start_q <= start_req;
			end
			S_LOAD: begin
				run_q   <= run_d;
				n_q     <= n_d;
				acc_q   <= acc_d;
				num_m_q <= num_m_d;
				den_q   <= den_d;
				last_q  <= (n_d == len_q - LEN_W'(1));
				neg_q   <= sidx_d[IDX_W-1];
				// odd quadrants run the quarter table backward
				if (sidx_d[IDX_W-2]) begin
					top_q      <= (j_d == '0);
					rom_addr_q <= QB'(0) - j_d;
				end else begin
					top_q      <= 1'b0;
					rom_addr_q <= j_d;
				end
			end
			S_ROM: begin
				mag_q <= top_q ? SINE_TOP : qrom[rom_addr_q];
			end
			S_MUL1: begin
				prod_q <= (2*PEAK_W)'(mag_q) * (2*PEAK_W)'(peak_q);
			end
			S_MUL2: begin
				rem_q <= NUM_W'(prod_q) * NUM_W'(num_m_q);
				dsh_q <= NUM_W'(DV_W'(den_q) * DV_W'(FULL_SCALE)) << (QUO_W - 1);
				quo_q <= '0;
				cnt_q <= '0;
			end
			S_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_DONE: begin
				if (out_free) begin
					if (run_q) begin
						sample_q <= neg_q ? (SMP_W'(0) - {1'b0, quo_q}) : {1'b0, quo_q};
					end else begin
						sample_q <= '0;
					end
					last_sample_q <= run_q && last_q;
					idle_q        <= !run_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_idle_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle |-> sample == '0 && !last_sample)
		else $error("idle beat carries a nonzero sample or last flag");

	a_within_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !idle |->
			(sample[SMP_W-1] ? (SMP_W'(0) - sample) : sample) <= {1'b0, peak_q})
		else $error("sample magnitude exceeds peak amplitude");

	a_wb_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |=> out_valid && state_q == S_IDLE)
		else $error("state write-back without an output beat");

	a_quo_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && run_q |-> quo_q <= peak_q)
		else $error("divider quotient above peak amplitude");
`endif

endmodule
